>>> src/ptrs_pkg.sv
`default_nettype none

package ptrs_pkg;

  // Default number of task slots in the table
  localparam int NumSlotsDefault = 8;

  // Command codes on command_i
  typedef enum logic [2:0] {
    CmdTick    = 3'd0,
    CmdCreate  = 3'd1,
    CmdSuspend = 3'd2,
    CmdResume  = 3'd3,
    CmdDelete  = 3'd4
  } cmd_e;

endpackage

`default_nettype wire

>>> src/periodic_task_release_scheduler_core.sv
// Channel    Handshake                    Payload
// ---------  ---------------------------  -------------------------------------------------
// command    start / busy (start & !busy)  command_i, slot_i, period_i, first_delay_i
// result     result_valid_o strobe         fired_o, fired_slot_o, tick_count_o, last_o
//
// Create, suspend, resume and delete take effect in the cycle they are accepted; busy stays low.
// A tick walks the slots in order, each through the single shared 16-bit decrementer, then
// emits the final item from the flush state. busy is high meanwhile.
// Results are one-cycle strobes; the receiver cannot stall, so every item is taken as shown.
// Reset (rst_ni low, asynchronous) clears in-use and running flags, the tick count and control.
// Period and countdown values are used only for slots in use, which create always writes first.
`default_nettype none

module periodic_task_release_scheduler_core
  import ptrs_pkg::*;
#(
  parameter int NUM_SLOTS = NumSlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [15:0] period_i,
  input  wire logic [7:0]  first_delay_i,
  output logic             result_valid_o,
  output logic             fired_o,
  output logic [2:0]       fired_slot_o,
  output logic [15:0]      tick_count_o,
  output logic             last_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFlush
  } state_e;

  state_e state_q;

  // Per-slot flags live in flops so reset clears them at once
  logic [NUM_SLOTS-1:0] in_use_q, running_q;

  // Period and countdown storage, one entry per slot, registered read
  logic [15:0] period_mem [NUM_SLOTS];
  logic [15:0] cd_mem     [NUM_SLOTS];
  logic [15:0] period_rd_q, cd_rd_q;

  logic [IdxW-1:0] cur_q;       // slot whose entry sits in the read registers
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] slot_idx;
  logic [15:0]     ticks_q;

  // A firing slot is held back until the next firing or the flush so that the last item can be marked
  logic            pend_valid_q;
  logic [IdxW-1:0] pend_slot_q;

  logic            out_valid_q, out_fired_q, out_last_q;
  logic [2:0]      out_slot_q;

  cmd_e        cmd;
  logic        accept;
  logic        slot_ok;
  logic        cur_last;
  logic        active;
  logic        cd_zero;
  logic [15:0] dec_in, dec_out;
  logic        cd_we, per_we;
  logic [IdxW-1:0] cd_wa;
  logic [15:0] cd_wd;

  assign cmd      = cmd_e'(command_i);
  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  assign slot_ok  = ({4'd0, slot_i} < 7'(NUM_SLOTS));
  assign slot_idx = IdxW'(slot_i);
  assign cur_last = (cur_q == IdxW'(NUM_SLOTS - 1));
  assign active   = in_use_q[cur_q] && running_q[cur_q];
  assign cd_zero  = (cd_rd_q == 16'd0);

  // Shared unit: reload from period minus one on zero, else count down
  assign dec_in  = cd_zero ? period_rd_q : cd_rd_q;
  assign dec_out = dec_in - 16'd1;

  // Prefetch the next slot while the current one is processed
  always_comb begin
    if (state_q == StWalk && !cur_last) begin
      rd_addr = cur_q + IdxW'(1);
    end else begin
      rd_addr = '0;
    end
  end

  // Countdown write port: walk writes back, create loads the first delay
  always_comb begin
    per_we = accept && (cmd == CmdCreate) && slot_ok;
    if (state_q == StWalk) begin
      cd_we = active;
      cd_wa = cur_q;
      cd_wd = dec_out;
    end else begin
      cd_we = per_we;
      cd_wa = slot_idx;
      cd_wd = {8'd0, first_delay_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_we) begin
      cd_mem[cd_wa] <= cd_wd;
    end
    if (per_we) begin
      period_mem[slot_idx] <= period_i;
    end
    cd_rd_q     <= cd_mem[rd_addr];
    period_rd_q <= period_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cur_q        <= '0;
      ticks_q      <= '0;
      in_use_q     <= '0;
      running_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (cmd == CmdTick) begin
              // Advance the tick count and start the walk at slot zero
              ticks_q      <= ticks_q + 16'd1;
              cur_q        <= '0;
              pend_valid_q <= 1'b0;
              state_q      <= StWalk;
            end else if (slot_ok) begin
              case (cmd)
                CmdCreate: begin
                  in_use_q[slot_idx]  <= 1'b1;
                  running_q[slot_idx] <= 1'b1;
                end
                CmdSuspend: running_q[slot_idx] <= 1'b0;
                CmdResume:  running_q[slot_idx] <= 1'b1;
                CmdDelete: begin
                  in_use_q[slot_idx]  <= 1'b0;
                  running_q[slot_idx] <= 1'b0;
                end
                default: ;  // drop unknown codes
              endcase
            end
          end
        end
        StWalk: begin
          if (active && cd_zero) begin
            // A later firing exists: release the held one as a non-final item
            if (pend_valid_q) begin
              out_valid_q <= 1'b1;
              out_fired_q <= 1'b1;
              out_slot_q  <= 3'(pend_slot_q);
              out_last_q  <= 1'b0;
            end
            pend_valid_q <= 1'b1;
            pend_slot_q  <= cur_q;
          end
          if (cur_last) begin
            state_q <= StFlush;
          end else begin
            cur_q <= cur_q + IdxW'(1);
          end
        end
        StFlush: begin
          // Emit the held firing, or the empty item, as the final one
          out_valid_q <= 1'b1;
          out_fired_q <= pend_valid_q;
          out_slot_q  <= pend_valid_q ? 3'(pend_slot_q) : 3'd0;
          out_last_q  <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_valid_o = out_valid_q;
  assign fired_o        = out_fired_q;
  assign fired_slot_o   = out_slot_q;
  assign tick_count_o   = ticks_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

>>> src/ptrs_checker.sv
`default_nettype none

module ptrs_checker
  import ptrs_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] command_i,
  input wire logic       result_valid_o,
  input wire logic       fired_o,
  input wire logic       last_o
);

  // An accepted tick starts a walk
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CmdTick) |=> busy)
    else $error("tick accepted without going busy");

  // The end of a walk always shows the final item
  a_fall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_o))
    else $error("walk ended without a final item");

  // Non-final items only appear while the walk runs
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("non-final item outside a walk");

  // An empty item is always the only, and final, one
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !fired_o) |-> last_o)
    else $error("empty item not marked final");

endmodule

bind periodic_task_release_scheduler_core ptrs_checker u_ptrs_checker (.*);

`default_nettype wire

>>> tb/periodic_task_release_scheduler_core_test.sv
`timescale 1ns / 100ps

module periodic_task_release_scheduler_core_test;
  import ptrs_pkg::*;

  localparam int NumSlots = NumSlotsDefault;
  localparam int ClkPeriod = 12;
  localparam int ResetCycles = 11;
  // Length of a tick: the walk over every slot through the shared decrementer plus the final emit
  localparam int TickCycles = NumSlots + 1;
  localparam int DrainLimit = 2000;
  localparam int MaxReports = 10;

  // Command codes outside the defined set; the block must ignore them
  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  // One result item as it appears on the result ports
  typedef struct packed {
    logic        fired;
    logic [2:0]  slot;
    logic [15:0] ticks;
    logic        last;
  } release_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  command_i;
  logic [2:0]  slot_i;
  logic [15:0] period_i;
  logic [7:0]  first_delay_i;
  logic        result_valid_o;
  logic        fired_o;
  logic [2:0]  fired_slot_o;
  logic [15:0] tick_count_o;
  logic        last_o;

  periodic_task_release_scheduler_core #(
    .NUM_SLOTS(NumSlots)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .slot_i        (slot_i),
    .period_i      (period_i),
    .first_delay_i (first_delay_i),
    .result_valid_o(result_valid_o),
    .fired_o       (fired_o),
    .fired_slot_o  (fired_slot_o),
    .tick_count_o  (tick_count_o),
    .last_o        (last_o)
  );

  // Shadow copy of the slot table, kept in step with every accepted item
  bit          slot_used   [NumSlots];
  bit          slot_active [NumSlots];
  logic [15:0] slot_reload [NumSlots];
  logic [15:0] slot_count  [NumSlots];
  logic [15:0] tick_total;

  // Release items predicted but not yet seen on the result ports, oldest first
  release_t pending_releases[$];

  int mismatches;
  int items_sent;
  int ticks_sent;
  int results_seen;
  int releases_seen;
  int sender_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Apply one accepted item to the shadow table and queue the release items it causes.
  // A tick walks the slots in ascending order: a zero countdown fires and reloads to
  // period - 1 (so a zero period reloads to 65535), any other countdown steps down.
  function automatic void predict_releases(input logic [2:0] cmd, input logic [2:0] slot,
                                           input logic [15:0] period, input logic [7:0] delay);
    logic [NumSlots-1:0] fire_mask;
    int                  remaining;
    release_t            rel;
    fire_mask = '0;
    if (cmd == CmdTick) begin
      tick_total = tick_total + 16'd1;
      for (int i = 0; i < NumSlots; i++) begin
        if (slot_used[i] && slot_active[i]) begin
          if (slot_count[i] == 16'd0) begin
            slot_count[i] = slot_reload[i] - 16'd1;
            fire_mask[i] = 1'b1;
          end else begin
            slot_count[i] = slot_count[i] - 16'd1;
          end
        end
      end
      remaining = $countones(fire_mask);
      if (remaining == 0) begin
        // Quiet tick: one empty item that still carries the tick count
        rel = {1'b0, 3'd0, tick_total, 1'b1};
        pending_releases.push_back(rel);
      end
      for (int i = 0; i < NumSlots; i++) begin
        if (fire_mask[i]) begin
          remaining--;
          rel = {1'b1, 3'(i), tick_total, remaining == 0};
          pending_releases.push_back(rel);
        end
      end
    end else if (int'(slot) < NumSlots) begin
      case (cmd)
        CmdCreate: begin
          // Overwrite whatever the slot held before
          slot_used[slot] = 1'b1;
          slot_active[slot] = 1'b1;
          slot_reload[slot] = period;
          slot_count[slot] = {8'd0, delay};
        end
        CmdSuspend: slot_active[slot] = 1'b0;
        CmdResume: slot_active[slot] = 1'b1;
        CmdDelete: begin
          slot_used[slot] = 1'b0;
          slot_active[slot] = 1'b0;
        end
        default: ;
      endcase
    end
  endfunction

  // Drive one item at the falling edge, hold it until accepted, then predict.
  // Drop start one cycle at a time while the current idle rate calls for it.
  task automatic send_item(input logic [2:0] cmd, input logic [2:0] slot,
                           input logic [15:0] period, input logic [7:0] delay);
    @(negedge clk_i);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    slot_i <= slot;
    period_i <= period;
    first_delay_i <= delay;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_releases(cmd, slot, period, delay);
    items_sent++;
    if (cmd == CmdTick) ticks_sent++;
  endtask

  task automatic note_mismatch(input string what, input release_t want, input release_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("ERROR %s at %0t: expected fired=%0d slot=%0d ticks=%0d last=%0d,",
               what, $realtime, want.fired, want.slot, want.ticks, want.last);
      $display("      got fired=%0d slot=%0d ticks=%0d last=%0d",
               got.fired, got.slot, got.ticks, got.last);
    end
  endtask

  // Take every strobed result and compare it with the oldest prediction
  always @(posedge clk_i) begin
    release_t got;
    release_t want;
    if (rst_ni && result_valid_o) begin
      got = {fired_o, fired_slot_o, tick_count_o, last_o};
      results_seen++;
      if (fired_o === 1'b1) releases_seen++;
      if (pending_releases.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_releases.pop_front();
        if (got.fired !== want.fired || got.slot !== want.slot ||
            got.ticks !== want.ticks || got.last !== want.last) begin
          note_mismatch("result differs", want, got);
        end
      end
    end
  end

  // Drop start, wait for all predicted items up to the drain limit, then wait out a tick and a margin
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_releases.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (TickCycles + 4) @(negedge clk_i);
  endtask

  // Walk each command on a few slots: plain release, zero-period reload, suspend and
  // resume, delete, resume of an unused slot, create over a live slot, spare codes.
  task automatic test_single_slot_commands();
    send_item(CmdCreate, 3'd0, 16'd1, 8'd0);
    send_item(CmdTick, 3'd7, 16'hFFFF, 8'hFF);
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
    send_item(CmdCreate, 3'd3, 16'd0, 8'd0);
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
    send_item(CmdCreate, 3'd7, 16'hFFFF, 8'hFF);
    send_item(CmdSuspend, 3'd0, 16'hFFFF, 8'hFF);
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
    send_item(CmdResume, 3'd0, 16'd0, 8'd0);
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
    send_item(CmdDelete, 3'd0, 16'd0, 8'd0);
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
    // Resume on a slot never created: nothing should fire from it
    send_item(CmdResume, 3'd5, 16'd0, 8'd0);
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
    // Create over a slot still in use replaces period and countdown
    send_item(CmdCreate, 3'd3, 16'd2, 8'd1);
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
    send_item(CmdSpare5, 3'd7, 16'hFFFF, 8'hFF);
    send_item(CmdSpare6, 3'd7, 16'hFFFF, 8'hFF);
    send_item(CmdSpare7, 3'd7, 16'hFFFF, 8'hFF);
    send_item(CmdSuspend, 3'd4, 16'd0, 8'd0);
  endtask

  // Fill every slot so one tick gives the most results it can
  task automatic test_full_table_release();
    for (int s = 0; s < NumSlots; s++) begin
      send_item(CmdCreate, 3'(s), 16'd1, 8'd0);
    end
    send_item(CmdTick, 3'd0, 16'd0, 8'd0);
  endtask

  // Mostly ticks over short periods so slots keep firing; the rest reshapes the table.
  // Each of period and delay is full-range a quarter of the time, to toggle the upper bits.
  task automatic test_random_traffic(input int count, input int idle_pct);
    int          pick;
    logic [2:0]  slot;
    logic [15:0] period;
    logic [7:0]  delay;
    logic [2:0]  spare;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      slot = 3'($urandom_range(NumSlots - 1));
      period = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
      delay = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(6));
      case ($urandom_range(2))
        0: spare = CmdSpare5;
        1: spare = CmdSpare6;
        default: spare = CmdSpare7;
      endcase
      if (pick < 55) send_item(CmdTick, slot, period, delay);
      else if (pick < 75) send_item(CmdCreate, slot, period, delay);
      else if (pick < 83) send_item(CmdSuspend, slot, period, delay);
      else if (pick < 91) send_item(CmdResume, slot, period, delay);
      else if (pick < 97) send_item(CmdDelete, slot, period, delay);
      else send_item(spare, slot, period, delay);
    end
  endtask

  initial begin
    // Drive every input to a known value before the first edge
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CmdTick;
    slot_i = 3'd0;
    period_i = 16'd0;
    first_delay_i = 8'd0;
    for (int s = 0; s < NumSlots; s++) begin
      slot_used[s] = 1'b0;
      slot_active[s] = 1'b0;
      slot_reload[s] = 16'd0;
      slot_count[s] = 16'd0;
    end
    tick_total = 16'd0;
    mismatches = 0;
    items_sent = 0;
    ticks_sent = 0;
    results_seen = 0;
    releases_seen = 0;
    sender_idle_pct = 21;

    // Hold reset, then release it away from the sampling edge
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_slot_commands();
    test_full_table_release();
    // Sweep the sender idle rate: lightly idle, heavily idle, then back to back
    test_random_traffic(67, 21);
    test_random_traffic(67, 47);
    test_random_traffic(66, 0);
    wait_drained();

    $display("Sent %0d items (%0d ticks); checked %0d results, %0d of them slot releases.",
             items_sent, ticks_sent, results_seen, releases_seen);
    $display("Covered all commands, spare codes, a full table and zero-period reload.");
    if (pending_releases.size() != 0) begin
      $display("ERROR %0d expected results never arrived", pending_releases.size());
    end
    if (mismatches > MaxReports) begin
      $display("ERROR %0d result mismatches in total", mismatches);
    end
    if (mismatches == 0 && pending_releases.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> periodic_task_release_scheduler_core.f
src/ptrs_pkg.sv
src/periodic_task_release_scheduler_core.sv
src/ptrs_checker.sv
tb/periodic_task_release_scheduler_core_test.sv
